// ===== hw/rtl/rpn_pkg.sv =====
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int DEPTH_OUT_W = 5;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W      = $clog2(DATA_W);
    localparam int M_TDATA_W   = ((DATA_W + DEPTH_OUT_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - DATA_W - DEPTH_OUT_W;

    // operation codes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5,
        OP_NEG  = 3'd6
    } calc_op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } calc_status_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

endpackage

// ===== hw/rtl/rpn_alu.sv =====
module rpn_alu (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rpn_pkg::alu_req_t         req,
    input  logic [rpn_pkg::DATA_W-1:0] opa,
    input  logic [rpn_pkg::DATA_W-1:0] opb,
    output rpn_pkg::alu_rsp_t         rsp,
    output logic [rpn_pkg::DATA_W-1:0] result
);
    import rpn_pkg::*;

    typedef enum logic [5:0] {
        A_IDLE = 6'b000001,
        A_ONE  = 6'b000010,
        A_ABSA = 6'b000100,
        A_ABSB = 6'b001000,
        A_LOOP = 6'b010000,
        A_FIX  = 6'b100000
    } alu_state_t;

    alu_state_t          state_reg, state_next;
    alu_op_t             op_reg, op_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [DATA_W-1:0]   x_reg, x_next;
    logic [DATA_W-1:0]   y_reg, y_next;
    logic [ITER_W-1:0]   cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [DATA_W-1:0]   res_reg, res_next;
    logic                done_reg, done_next;

    // the one shared adder
    logic [DATA_W-1:0]   add_a, add_b;
    logic                add_sub;
    logic [DATA_W:0]     add_sum;
    logic [DATA_W-1:0]   rem_sh;
    logic                last_iter;

    assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {{DATA_W{1'b0}}, add_sub};
    assign rem_sh    = {acc_reg[DATA_W-2:0], x_reg[DATA_W-1]};
    assign last_iter = (cnt_reg == ITER_W'(DATA_W - 1));

    always_comb begin
        add_a   = x_reg;
        add_b   = y_reg;
        add_sub = 1'b0;
        unique case (state_reg)
            A_ONE: begin
                add_sub = (op_reg == ALU_SUB);
            end
            A_ABSA, A_FIX: begin
                add_a   = '0;
                add_b   = x_reg;
                add_sub = 1'b1;
            end
            A_ABSB: begin
                add_a   = '0;
                add_b   = y_reg;
                add_sub = 1'b1;
            end
            A_LOOP: begin
                if (op_reg == ALU_DIV) begin
                    add_a   = rem_sh;
                    add_b   = y_reg;
                    add_sub = 1'b1;
                end else begin
                    add_a = acc_reg;
                    add_b = x_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    op_next  = req.op;
                    x_next   = opa;
                    y_next   = opb;
                    acc_next = '0;
                    cnt_next = '0;
                    neg_next = opa[DATA_W-1] ^ opb[DATA_W-1];
                    unique case (req.op)
                        ALU_ADD, ALU_SUB: state_next = A_ONE;
                        ALU_MUL:          state_next = A_LOOP;
                        ALU_DIV:          state_next = A_ABSA;
                        default:          state_next = A_IDLE;
                    endcase
                end
            end
            A_ONE: begin
                res_next   = add_sum[DATA_W-1:0];
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_ABSA: begin
                if (x_reg[DATA_W-1]) begin
                    x_next = add_sum[DATA_W-1:0];
                end
                state_next = A_ABSB;
            end
            A_ABSB: begin
                if (y_reg[DATA_W-1]) begin
                    y_next = add_sum[DATA_W-1:0];
                end
                state_next = A_LOOP;
            end
            A_LOOP: begin
                cnt_next = cnt_reg + ITER_W'(1);
                if (op_reg == ALU_DIV) begin
                    // carry out of the subtract means rem_sh >= divisor
                    acc_next = add_sum[DATA_W] ? add_sum[DATA_W-1:0] : rem_sh;
                    x_next   = {x_reg[DATA_W-2:0], add_sum[DATA_W]};
                    if (last_iter) begin
                        state_next = A_FIX;
                    end
                end else begin
                    acc_next = y_reg[0] ? add_sum[DATA_W-1:0] : acc_reg;
                    x_next   = {x_reg[DATA_W-2:0], 1'b0};
                    y_next   = {1'b0, y_reg[DATA_W-1:1]};
                    if (last_iter) begin
                        res_next   = acc_next;
                        done_next  = 1'b1;
                        state_next = A_IDLE;
                    end
                end
            end
            A_FIX: begin
                res_next   = neg_reg ? add_sum[DATA_W-1:0] : x_reg;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        op_reg  <= op_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.busy = (state_reg != A_IDLE);
    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule

// ===== hw/rtl/postfix_stack_calculator.sv =====
// postfix (rpn) calculator on a bounded stack of 32-bit signed integers.
// each s_ transfer carries one operation in s_tuser (push, pop, add, sub,
// mul, div, negate) and a push value in s_tdata; each operation yields
// exactly one m_ transfer with the new top of stack (zero when empty), the
// depth and a status (ok, underflow, overflow, divide by zero). on an error
// the stack is left unchanged. arithmetic wraps to 32 bits and division
// truncates toward zero. the block works on one operation at a time:
// s_tready is high only while idle. an input transfer is captured while
// idle and then decoded; push, pop, undefined codes and errors go straight
// to the done state, while add, sub, negate, multiply and divide first wait
// for the arithmetic unit. the done state loads the result into the output
// register once that is free, and s_tready returns in the cycle after the
// load. multiply and divide run on the shared shift-and-add / shift-and-subtract
// unit, which handles one bit per cycle (32 steps, plus two sign steps and one
// fixup step for divide). the top entry lives in a register and the rest of
// the stack in a memory with one write and one read port, so every operation
// needs at most one read. the result sits in an output register, so the next
// operation may be taken while a result waits for m_tready.
module postfix_stack_calculator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rpn_pkg::DATA_W-1:0]       s_tdata,   // [31:0] operand_value
    input  logic [rpn_pkg::OP_W-1:0]         s_tuser,   // [2:0] operation
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rpn_pkg::M_TDATA_W-1:0]    m_tdata,   // [31:0] top_value,
                                                        // [36:32] stack_depth
    output logic [rpn_pkg::ST_W-1:0]         m_tuser    // [1:0] status
);
    import rpn_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_WAIT   = 5'b00100,
        S_DONE   = 5'b01000,
        S_SPARE  = 5'b10000
    } calc_state_t;

    calc_state_t          state_reg, state_next;
    calc_op_t             op_reg, op_next;
    logic [DATA_W-1:0]    val_reg, val_next;
    logic [DATA_W-1:0]    tos_reg, tos_next;      // top entry of the stack
    logic [CNT_W-1:0]     count_reg, count_next;
    calc_status_t         status_reg, status_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]    m_top_reg, m_top_next;
    logic [DEPTH_OUT_W-1:0] m_depth_reg, m_depth_next;
    calc_status_t         m_status_reg, m_status_next;

    // entries below the top
    logic [DATA_W-1:0]    stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 mem_we;
    logic [CNT_W-1:0]     cnt_m1, cnt_m2;
    logic [PTR_W-1:0]     wr_ptr, rd_ptr;

    logic                       s_xfer;
    logic                       out_free;
    logic                       is_empty, has_two, is_full;
    logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;

    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;
    logic [DATA_W-1:0]    alu_a, alu_b, alu_res;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign is_empty = (count_reg == '0);
    assign has_two  = (count_reg > CNT_W'(1));
    assign is_full  = (count_reg == CNT_W'(STACK_DEPTH));

    // memory slot of the one being pushed down, and of the entry just below the top
    assign cnt_m1 = count_reg - CNT_W'(1);
    assign cnt_m2 = count_reg - CNT_W'(2);
    assign wr_ptr = cnt_m1[PTR_W-1:0];
    assign rd_ptr = cnt_m2[PTR_W-1:0];

    // second entry is read every cycle; count and memory hold still while idle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_ptr] <= tos_reg;
        end
        rd_data_reg <= stack_mem[rd_ptr];
    end

    rpn_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_a),
        .opb     (alu_b),
        .rsp     (alu_rsp),
        .result  (alu_res)
    );

    // negate runs as 0 - top, binary ops take second entry as the left operand
    assign alu_a = (op_reg == OP_NEG) ? '0 : rd_data_reg;
    assign alu_b = tos_reg;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        tos_next      = tos_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_top_next    = m_top_reg;
        m_depth_next  = m_depth_reg;
        m_status_next = m_status_reg;
        mem_we        = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    op_next    = calc_op_t'(s_tuser);
                    val_next   = s_tdata;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                status_next = ST_OK;
                state_next  = S_DONE;
                unique case (op_reg)
                    OP_PUSH: begin
                        if (is_full) begin
                            status_next = ST_OVER;
                        end else begin
                            mem_we     = !is_empty;
                            tos_next   = val_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_POP: begin
                        if (is_empty) begin
                            status_next = ST_UNDER;
                        end else begin
                            tos_next   = rd_data_reg;
                            count_next = cnt_m1;
                        end
                    end
                    OP_NEG: begin
                        if (is_empty) begin
                            status_next = ST_UNDER;
                        end else begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_SUB;
                            state_next    = S_WAIT;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (!has_two) begin
                            status_next = ST_UNDER;
                        end else if ((op_reg == OP_DIV) && (tos_reg == '0)) begin
                            status_next = ST_DIVZ;
                        end else begin
                            alu_req.start = 1'b1;
                            unique case (op_reg)
                                OP_ADD:  alu_req.op = ALU_ADD;
                                OP_SUB:  alu_req.op = ALU_SUB;
                                OP_MUL:  alu_req.op = ALU_MUL;
                                default: alu_req.op = ALU_DIV;
                            endcase
                            state_next = S_WAIT;
                        end
                    end
                    default: begin
                        // undefined code: no change, status ok
                    end
                endcase
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    tos_next = alu_res;
                    if (op_reg != OP_NEG) begin
                        count_next = cnt_m1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_top_next    = is_empty ? '0 : tos_reg;
                    m_depth_next  = depth_ext[DEPTH_OUT_W-1:0];
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign depth_ext = {{DEPTH_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        val_reg      <= val_next;
        tos_reg      <= tos_next;
        status_reg   <= status_next;
        m_top_reg    <= m_top_next;
        m_depth_reg  <= m_depth_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_depth_reg, m_top_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== hw/rtl/rpn_checker.sv =====
module rpn_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rpn_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [rpn_pkg::ST_W-1:0]         m_tuser
);
    import rpn_pkg::*;

    logic [DEPTH_OUT_W-1:0] depth;
    logic [DATA_W-1:0]      top;

    assign depth = m_tdata[DATA_W+DEPTH_OUT_W-1:DATA_W];
    assign top   = m_tdata[DATA_W-1:0];

    // one operation at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    a_empty_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (depth == '0) |-> (top == '0))
        else $error("nonzero top value on an empty stack");

    a_underflow_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_UNDER) |-> (depth <= DEPTH_OUT_W'(1)))
        else $error("underflow reported with two or more entries");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind postfix_stack_calculator rpn_checker u_rpn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
